FILE: design/czc_pkg.sv
// ----------------------------------------------------------------------------
// czc_pkg: shared types and codes of the call zone classifier
// Command and status codes, field limits and the words that travel along
// the exchange and cost cell chains.
// ----------------------------------------------------------------------------
package czc_pkg;

	// command codes
	localparam logic [1:0] CMD_ADD_EXCH   = 2'd0;
	localparam logic [1:0] CMD_ADD_COST   = 2'd1;
	localparam logic [1:0] CMD_ADD_RATE   = 2'd2;
	localparam logic [1:0] CMD_LOOKUP     = 2'd3;

	// result status codes
	localparam logic [3:0] ST_ACCEPTED    = 4'd0;
	localparam logic [3:0] ST_FULL        = 4'd1;
	localparam logic [3:0] ST_LOCAL       = 4'd2;
	localparam logic [3:0] ST_ZONE_COST   = 4'd3;
	localparam logic [3:0] ST_ZONE_NOCOST = 4'd4;
	localparam logic [3:0] ST_LONG        = 4'd5;
	localparam logic [3:0] ST_RATE        = 4'd6;
	localparam logic [3:0] ST_BAD_NUMBER  = 4'd7;
	localparam logic [3:0] ST_BAD_ENTRY   = 4'd8;

	// field limits
	localparam logic [9:0] NUM_LOW     = 10'd100;
	localparam logic [9:0] NUM_HIGH    = 10'd999;
	localparam logic [6:0] ZONE_MAX    = 7'd99;
	localparam logic [4:0] HOUR_MAX    = 5'd24;
	localparam logic [6:0] PERCENT_MAX = 7'd100;

	// lookup word walking the exchange chain
	typedef struct packed {
		logic       vld;
		logic [9:0] area;
		logic [9:0] exch;
		logic       found;
		logic [6:0] zone;
	} xtok_t;

	// lookup word walking the cost chain
	typedef struct packed {
		logic        vld;
		logic [6:0]  zone;
		logic        found;
		logic [15:0] first;
		logic [15:0] next;
	} ctok_t;

	// reduced-rate entry
	typedef struct packed {
		logic [4:0] from_hr;
		logic [4:0] to_hr;
		logic [6:0] pct;
	} rate_ent_t;

endpackage

FILE: design/czc_xcell.sv
// ----------------------------------------------------------------------------
// czc_xcell: one exchange table cell
// Holds one exchange entry and compares it against the lookup word passing
// by; the first live cell that matches marks the word found.
// ----------------------------------------------------------------------------
module czc_xcell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [6:0]     wr_zone,
	input  logic [9:0]     wr_area,
	input  logic [9:0]     wr_exch,
	input  logic           live,
	input  czc_pkg::xtok_t tok_in,
	output czc_pkg::xtok_t tok_out
);
	import czc_pkg::*;

	logic [6:0] zone_q;
	logic [9:0] area_q;
	logic [9:0] exch_q;
	xtok_t      tok_d;
	xtok_t      tok_q;
	logic       hit;

	// store the entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			zone_q <= wr_zone;
			area_q <= wr_area;
			exch_q <= wr_exch;
		end
	end

	// mark the word on the first match
	assign hit = tok_in.vld && live && !tok_in.found &&
		(tok_in.area == area_q) && (tok_in.exch == exch_q);

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.found = 1'b1;
			tok_d.zone  = zone_q;
		end
	end

	// advance the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: design/czc_ccell.sv
// ----------------------------------------------------------------------------
// czc_ccell: one cost table cell
// Holds one zone cost entry and fills in the costs of the lookup word passing
// by when its zone matches and no earlier cell matched.
// ----------------------------------------------------------------------------
module czc_ccell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [6:0]     wr_zone,
	input  logic [15:0]    wr_first,
	input  logic [15:0]    wr_next,
	input  logic           live,
	input  czc_pkg::ctok_t tok_in,
	output czc_pkg::ctok_t tok_out
);
	import czc_pkg::*;

	logic [6:0]  zone_q;
	logic [15:0] first_q;
	logic [15:0] next_q;
	ctok_t       tok_d;
	ctok_t       tok_q;
	logic        hit;

	// store the entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			zone_q  <= wr_zone;
			first_q <= wr_first;
			next_q  <= wr_next;
		end
	end

	// fill in costs on the first match
	assign hit = tok_in.vld && live && !tok_in.found && (tok_in.zone == zone_q);

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.found = 1'b1;
			tok_d.first = first_q;
			tok_d.next  = next_q;
		end
	end

	// advance the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: design/call_zone_classifier.sv
// ----------------------------------------------------------------------------
// call_zone_classifier: dialled number zone and cost classifier
// Each add command gives its result in the cycle after it is taken. A lookup
// of a valid number walks the exchange cell chain, then, for a zone call,
// the cost cell chain; a long distance answer is followed by one word per
// stored reduced-rate entry, one a cycle. busy is high while a lookup runs.
// Results appear on the result ports for one cycle with valid high and
// cannot be held off: the receiver must take every word as it comes.
// ----------------------------------------------------------------------------
module call_zone_classifier #(
	parameter int EXCHANGE_ENTRIES  = 64,
	parameter int COST_ENTRIES      = 16,
	parameter int REDUCTION_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [9:0]  area_num,
	input  logic [9:0]  exchange,
	input  logic [6:0]  zone,
	input  logic [15:0] first_minute_cost,
	input  logic [15:0] next_minute_cost,
	input  logic [4:0]  from_hour,
	input  logic [4:0]  to_hour,
	input  logic [6:0]  percent_off,
	output logic        valid,
	output logic [3:0]  status,
	output logic [6:0]  zone_out,
	output logic [15:0] first_cost_out,
	output logic [15:0] next_cost_out,
	output logic [4:0]  from_out,
	output logic [4:0]  to_out,
	output logic [6:0]  percent_out,
	output logic        last
);
	import czc_pkg::*;

	localparam int XCW = $clog2(EXCHANGE_ENTRIES + 1);
	localparam int CCW = $clog2(COST_ENTRIES + 1);
	localparam int RCW = $clog2(REDUCTION_ENTRIES + 1);
	localparam int RIW = (REDUCTION_ENTRIES > 1) ? $clog2(REDUCTION_ENTRIES) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_XSCAN = 4'b0010,
		S_CSCAN = 4'b0100,
		S_RATE  = 4'b1000
	} state_t;

	state_t          state_q, state_d;
	logic [XCW-1:0]  x_count_q;
	logic [CCW-1:0]  c_count_q;
	logic [RCW-1:0]  r_count_q;
	logic [RCW-1:0]  r_idx_q, r_idx_d;
	rate_ent_t       rtab_q [REDUCTION_ENTRIES];
	rate_ent_t       r_ent;

	xtok_t           xtok [EXCHANGE_ENTRIES+1];
	ctok_t           ctok [COST_ENTRIES+1];

	logic            accept;
	logic            bad_x, bad_c, bad_r, bad_num;
	logic            x_full, c_full, r_full;
	logic            x_wr, c_wr, r_wr;
	logic            x_launch, c_launch;

	logic            o_valid, o_last;
	logic [3:0]      o_status;
	logic [6:0]      o_zone, o_pct;
	logic [15:0]     o_first, o_next;
	logic [4:0]      o_from, o_to;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// range checks
	assign bad_x   = (zone > ZONE_MAX) || (area_num > NUM_HIGH) || (exchange > NUM_HIGH);
	assign bad_c   = (zone > ZONE_MAX);
	assign bad_r   = (from_hour > HOUR_MAX) || (to_hour > HOUR_MAX) ||
		(percent_off > PERCENT_MAX);
	assign bad_num = (area_num < NUM_LOW) || (area_num > NUM_HIGH) ||
		(exchange < NUM_LOW) || (exchange > NUM_HIGH);

	assign x_full = (x_count_q == XCW'(EXCHANGE_ENTRIES));
	assign c_full = (c_count_q == CCW'(COST_ENTRIES));
	assign r_full = (r_count_q == RCW'(REDUCTION_ENTRIES));

	assign x_wr     = accept && (cmd == CMD_ADD_EXCH) && !bad_x && !x_full;
	assign c_wr     = accept && (cmd == CMD_ADD_COST) && !bad_c && !c_full;
	assign r_wr     = accept && (cmd == CMD_ADD_RATE) && !bad_r && !r_full;
	assign x_launch = accept && (cmd == CMD_LOOKUP) && !bad_num;

	// exchange cell chain
	always_comb begin
		xtok[0]       = '0;
		xtok[0].vld   = x_launch;
		xtok[0].area  = area_num;
		xtok[0].exch  = exchange;
	end

	for (genvar i = 0; i < EXCHANGE_ENTRIES; i++) begin : g_xcell
		czc_xcell u_xcell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (x_wr && (x_count_q == XCW'(i))),
			.wr_zone (zone),
			.wr_area (area_num),
			.wr_exch (exchange),
			.live    (XCW'(i) < x_count_q),
			.tok_in  (xtok[i]),
			.tok_out (xtok[i+1])
		);
	end

	// cost cell chain, fed by the zone of the exchange match
	always_comb begin
		ctok[0]      = '0;
		ctok[0].vld  = c_launch;
		ctok[0].zone = xtok[EXCHANGE_ENTRIES].zone;
	end

	for (genvar j = 0; j < COST_ENTRIES; j++) begin : g_ccell
		czc_ccell u_ccell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (c_wr && (c_count_q == CCW'(j))),
			.wr_zone  (zone),
			.wr_first (first_minute_cost),
			.wr_next  (next_minute_cost),
			.live     (CCW'(j) < c_count_q),
			.tok_in   (ctok[j]),
			.tok_out  (ctok[j+1])
		);
	end

	// reduced-rate entries
	always_ff @(posedge clk) begin
		if (r_wr) begin
			rtab_q[r_count_q[RIW-1:0]] <= '{from_hr: from_hour, to_hr: to_hour,
				pct: percent_off};
		end
	end

	assign r_ent = rtab_q[r_idx_q[RIW-1:0]];

	// table fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_count_q <= '0;
			c_count_q <= '0;
			r_count_q <= '0;
		end else begin
			if (x_wr) x_count_q <= x_count_q + XCW'(1);
			if (c_wr) c_count_q <= c_count_q + CCW'(1);
			if (r_wr) r_count_q <= r_count_q + RCW'(1);
		end
	end

	// sequence the lookup and form each result word
	always_comb begin
		state_d  = state_q;
		r_idx_d  = r_idx_q;
		c_launch = 1'b0;
		o_valid  = 1'b0;
		o_status = ST_ACCEPTED;
		o_zone   = '0;
		o_first  = '0;
		o_next   = '0;
		o_from   = '0;
		o_to     = '0;
		o_pct    = '0;
		o_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					o_valid = 1'b1;
					unique case (cmd)
						CMD_ADD_EXCH: begin
							if (bad_x) o_status = ST_BAD_ENTRY;
							else if (x_full) o_status = ST_FULL;
						end
						CMD_ADD_COST: begin
							if (bad_c) o_status = ST_BAD_ENTRY;
							else if (c_full) o_status = ST_FULL;
						end
						CMD_ADD_RATE: begin
							if (bad_r) o_status = ST_BAD_ENTRY;
							else if (r_full) o_status = ST_FULL;
						end
						CMD_LOOKUP: begin
							if (bad_num) begin
								o_status = ST_BAD_NUMBER;
							end else begin
								o_valid = 1'b0;
								state_d = S_XSCAN;
							end
						end
						default: o_valid = 1'b0;
					endcase
				end
			end
			S_XSCAN: begin
				if (xtok[EXCHANGE_ENTRIES].vld) begin
					priority if (!xtok[EXCHANGE_ENTRIES].found) begin
						o_valid  = 1'b1;
						o_status = ST_LONG;
						o_last   = (r_count_q == '0);
						r_idx_d  = '0;
						state_d  = (r_count_q == '0) ? S_IDLE : S_RATE;
					end else if (xtok[EXCHANGE_ENTRIES].zone == '0) begin
						o_valid  = 1'b1;
						o_status = ST_LOCAL;
						state_d  = S_IDLE;
					end else begin
						c_launch = 1'b1;
						state_d  = S_CSCAN;
					end
				end
			end
			S_CSCAN: begin
				if (ctok[COST_ENTRIES].vld) begin
					o_valid = 1'b1;
					o_zone  = ctok[COST_ENTRIES].zone;
					if (ctok[COST_ENTRIES].found) begin
						o_status = ST_ZONE_COST;
						o_first  = ctok[COST_ENTRIES].first;
						o_next   = ctok[COST_ENTRIES].next;
					end else begin
						o_status = ST_ZONE_NOCOST;
					end
					state_d = S_IDLE;
				end
			end
			S_RATE: begin
				o_valid  = 1'b1;
				o_status = ST_RATE;
				o_from   = r_ent.from_hr;
				o_to     = r_ent.to_hr;
				o_pct    = r_ent.pct;
				o_last   = ((r_idx_q + RCW'(1)) == r_count_q);
				r_idx_d  = r_idx_q + RCW'(1);
				if (o_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_idx_q <= '0;
			valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			r_idx_q <= r_idx_d;
			valid   <= o_valid;
		end
	end

	// register the result word
	always_ff @(posedge clk) begin
		status         <= o_status;
		zone_out       <= o_zone;
		first_cost_out <= o_first;
		next_cost_out  <= o_next;
		from_out       <= o_from;
		to_out         <= o_to;
		percent_out    <= o_pct;
		last           <= o_last;
	end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: call zone classifier check
// Loads the exchange, cost and reduced-rate tables through command words and
// classifies dialled numbers against them. A model of the tables inside the
// bench predicts each result word. A monitor compares every strobed result,
// field by field, with the oldest prediction. Directed cases cover rejected
// entries, bad numbers, duplicate entries, every lookup outcome and full
// tables. A random mix of loads and lookups follows, with random idle gaps.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import czc_pkg::*;

	localparam int EXCH_DEPTH  = 64;
	localparam int COST_DEPTH  = 16;
	localparam int RATE_DEPTH  = 8;
	localparam int SETTLE      = 120;
	localparam int CYCLE_LIMIT = 500000;

	// one command word as driven on the ports
	typedef struct {
		bit [1:0]  cmd;
		bit [9:0]  area;
		bit [9:0]  exch;
		bit [6:0]  zone;
		bit [15:0] first;
		bit [15:0] next;
		bit [4:0]  from_hr;
		bit [4:0]  to_hr;
		bit [6:0]  pct;
	} word_t;

	// one result word as predicted
	typedef struct {
		bit [3:0]  status;
		bit [6:0]  zone;
		bit [15:0] first;
		bit [15:0] next;
		bit [4:0]  from_hr;
		bit [4:0]  to_hr;
		bit [6:0]  pct;
		bit        last;
	} answer_t;

	typedef struct {
		bit [6:0] zone;
		bit [9:0] area;
		bit [9:0] exch;
	} exch_cell_t;

	typedef struct {
		bit [6:0]  zone;
		bit [15:0] first;
		bit [15:0] next;
	} cost_cell_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [9:0]  area_num;
	logic [9:0]  exchange;
	logic [6:0]  zone;
	logic [15:0] first_minute_cost;
	logic [15:0] next_minute_cost;
	logic [4:0]  from_hour;
	logic [4:0]  to_hour;
	logic [6:0]  percent_off;
	logic        valid;
	logic [3:0]  status;
	logic [6:0]  zone_out;
	logic [15:0] first_cost_out;
	logic [15:0] next_cost_out;
	logic [4:0]  from_out;
	logic [4:0]  to_out;
	logic [6:0]  percent_out;
	logic        last;

	// bench copy of the tables, in load order
	exch_cell_t exch_tab [$];
	cost_cell_t cost_tab [$];
	rate_ent_t  rate_tab [$];
	int         exch_fill;
	int         cost_fill;
	int         rate_fill;

	answer_t    pending [$];
	answer_t    due;
	int         errors = 0;
	int         cycles = 0;
	int         gap_max;

	call_zone_classifier #(
		.EXCHANGE_ENTRIES  (EXCH_DEPTH),
		.COST_ENTRIES      (COST_DEPTH),
		.REDUCTION_ENTRIES (RATE_DEPTH)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.cmd               (cmd),
		.area_num          (area_num),
		.exchange          (exchange),
		.zone              (zone),
		.first_minute_cost (first_minute_cost),
		.next_minute_cost  (next_minute_cost),
		.from_hour         (from_hour),
		.to_hour           (to_hour),
		.percent_off       (percent_off),
		.valid             (valid),
		.status            (status),
		.zone_out          (zone_out),
		.first_cost_out    (first_cost_out),
		.next_cost_out     (next_cost_out),
		.from_out          (from_out),
		.to_out            (to_out),
		.percent_out       (percent_out),
		.last              (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("call_zone_classifier verification failed");
			$finish;
		end
	end

	// print one mismatch and count it
	task automatic flag(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	// classify one accepted word and queue the result words it causes
	function automatic void classify_word(input word_t w);
		answer_t    r;
		bit         hit;
		bit         priced;
		bit [6:0]   z;
		int         i;
		exch_cell_t xe;
		cost_cell_t ce;
		rate_ent_t  re;
		r = '{default: 0};
		r.last = 1'b1;
		hit = 1'b0;
		priced = 1'b0;
		z = '0;
		case (w.cmd)
			CMD_ADD_EXCH: begin
				if (w.zone > ZONE_MAX || w.area > NUM_HIGH || w.exch > NUM_HIGH) begin
					r.status = ST_BAD_ENTRY;
				end else if (exch_fill >= EXCH_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					xe = '{zone: w.zone, area: w.area, exch: w.exch};
					exch_tab.push_back(xe);
					exch_fill++;
					r.status = ST_ACCEPTED;
				end
				pending.push_back(r);
			end
			CMD_ADD_COST: begin
				if (w.zone > ZONE_MAX) begin
					r.status = ST_BAD_ENTRY;
				end else if (cost_fill >= COST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ce = '{zone: w.zone, first: w.first, next: w.next};
					cost_tab.push_back(ce);
					cost_fill++;
					r.status = ST_ACCEPTED;
				end
				pending.push_back(r);
			end
			CMD_ADD_RATE: begin
				if (w.from_hr > HOUR_MAX || w.to_hr > HOUR_MAX || w.pct > PERCENT_MAX) begin
					r.status = ST_BAD_ENTRY;
				end else if (rate_fill >= RATE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					re = '{from_hr: w.from_hr, to_hr: w.to_hr, pct: w.pct};
					rate_tab.push_back(re);
					rate_fill++;
					r.status = ST_ACCEPTED;
				end
				pending.push_back(r);
			end
			default: begin
				if (w.area < NUM_LOW || w.area > NUM_HIGH ||
						w.exch < NUM_LOW || w.exch > NUM_HIGH) begin
					r.status = ST_BAD_NUMBER;
					pending.push_back(r);
				end else begin
					// first matching exchange entry wins
					for (i = 0; i < exch_fill; i++) begin
						if (!hit && exch_tab[i].area == w.area && exch_tab[i].exch == w.exch) begin
							hit = 1'b1;
							z = exch_tab[i].zone;
						end
					end
					if (hit && z == 0) begin
						r.status = ST_LOCAL;
						pending.push_back(r);
					end else if (hit) begin
						// first cost entry of that zone wins
						for (i = 0; i < cost_fill; i++) begin
							if (!priced && cost_tab[i].zone == z) begin
								priced = 1'b1;
								r.first = cost_tab[i].first;
								r.next = cost_tab[i].next;
							end
						end
						r.status = priced ? ST_ZONE_COST : ST_ZONE_NOCOST;
						r.zone = z;
						pending.push_back(r);
					end else begin
						// long distance, then every reduced-rate entry in load order
						r.status = ST_LONG;
						r.last = (rate_fill == 0);
						pending.push_back(r);
						for (i = 0; i < rate_fill; i++) begin
							r = '{default: 0};
							r.status = ST_RATE;
							r.from_hr = rate_tab[i].from_hr;
							r.to_hr = rate_tab[i].to_hr;
							r.pct = rate_tab[i].pct;
							r.last = (i + 1 == rate_fill);
							pending.push_back(r);
						end
					end
				end
			end
		endcase
	endfunction

	// check every strobed result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (pending.size() == 0) begin
				flag("result word with nothing pending, status", 16'(status), 16'd0);
			end else begin
				due = pending.pop_front();
				if (status !== due.status)
					flag("status", 16'(status), 16'(due.status));
				if (zone_out !== due.zone)
					flag("zone_out", 16'(zone_out), 16'(due.zone));
				if (first_cost_out !== due.first)
					flag("first_cost_out", first_cost_out, due.first);
				if (next_cost_out !== due.next)
					flag("next_cost_out", next_cost_out, due.next);
				if (from_out !== due.from_hr)
					flag("from_out", 16'(from_out), 16'(due.from_hr));
				if (to_out !== due.to_hr)
					flag("to_out", 16'(to_out), 16'(due.to_hr));
				if (percent_out !== due.pct)
					flag("percent_out", 16'(percent_out), 16'(due.pct));
				if (last !== due.last)
					flag("last", 16'(last), 16'(due.last));
			end
		end
	end

	// fully random word, also the base of every directed word
	function automatic word_t random_word();
		word_t w;
		w.cmd = 2'($urandom_range(0, 3));
		w.area = 10'($urandom_range(0, 1023));
		w.exch = 10'($urandom_range(0, 1023));
		w.zone = 7'($urandom_range(0, 127));
		w.first = 16'($urandom_range(0, 65535));
		w.next = 16'($urandom_range(0, 65535));
		w.from_hr = 5'($urandom_range(0, 31));
		w.to_hr = 5'($urandom_range(0, 31));
		w.pct = 7'($urandom_range(0, 127));
		return w;
	endfunction

	// send one word: hold start until taken, predict, then idle a random while
	task automatic send_word(input word_t w);
		int gap;
		@(negedge clk);
		cmd <= w.cmd;
		area_num <= w.area;
		exchange <= w.exch;
		zone <= w.zone;
		first_minute_cost <= w.first;
		next_minute_cost <= w.next;
		from_hour <= w.from_hr;
		to_hour <= w.to_hr;
		percent_off <= w.pct;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		classify_word(w);
		gap = $urandom_range(0, gap_max);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic add_exchange(input int a, input int x, input int z);
		word_t w;
		w = random_word();
		w.cmd = CMD_ADD_EXCH;
		w.area = 10'(a);
		w.exch = 10'(x);
		w.zone = 7'(z);
		send_word(w);
	endtask

	task automatic add_cost(input int z, input int f, input int n);
		word_t w;
		w = random_word();
		w.cmd = CMD_ADD_COST;
		w.zone = 7'(z);
		w.first = 16'(f);
		w.next = 16'(n);
		send_word(w);
	endtask

	task automatic add_rate(input int f, input int t, input int p);
		word_t w;
		w = random_word();
		w.cmd = CMD_ADD_RATE;
		w.from_hr = 5'(f);
		w.to_hr = 5'(t);
		w.pct = 7'(p);
		send_word(w);
	endtask

	task automatic lookup(input int a, input int x);
		word_t w;
		w = random_word();
		w.cmd = CMD_LOOKUP;
		w.area = 10'(a);
		w.exch = 10'(x);
		send_word(w);
	endtask

	// zones mostly from a small pool so lookups find prices, now and then anything
	function automatic int pick_zone();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 11);
	endfunction

	// numbers mostly from a small pool so that entries collide and lookups hit
	function automatic int pick_number(input int base);
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) :
			base + $urandom_range(0, 15);
	endfunction

	// out-of-range fields on every add command
	task automatic test_bad_entries();
		add_exchange(500, 500, 100);
		add_exchange(1023, 500, 5);
		add_exchange(500, 1000, 5);
		add_cost(127, 65535, 65535);
		add_rate(25, 0, 0);
		add_rate(0, 31, 0);
		add_rate(0, 0, 101);
	endtask

	// every lookup outcome, duplicates and range edges
	task automatic test_lookup_cases();
		lookup(99, 500);
		lookup(1000, 500);
		lookup(500, 99);
		lookup(500, 1023);
		// long distance with no reduced-rate entries ends on the first word
		lookup(100, 100);
		add_exchange(100, 100, 0);
		add_exchange(999, 999, 99);
		add_exchange(999, 999, 1);
		add_exchange(0, 0, 3);
		add_cost(99, 65535, 0);
		add_cost(99, 0, 65535);
		lookup(100, 100);
		lookup(999, 999);
		add_exchange(555, 555, 42);
		lookup(555, 555);
		add_rate(0, 24, 100);
		add_rate(24, 0, 0);
		lookup(123, 456);
	endtask

	// random mix of loads and lookups, gaps on and off in stretches
	task automatic test_random_mix(input int count);
		int     n;
		int     pick;
		int     k;
		word_t  w;
		for (n = 0; n < count; n++) begin
			if (n % 25 == 0) gap_max = (gap_max == 0) ? 14 : 0;
			pick = $urandom_range(0, 99);
			if (pick < 35 && exch_fill > 0) begin
				k = $urandom_range(0, exch_fill - 1);
				lookup(int'(exch_tab[k].area), int'(exch_tab[k].exch));
			end else if (pick < 50) begin
				lookup($urandom_range(0, 1023), $urandom_range(0, 1023));
			end else if (pick < 70) begin
				add_exchange(pick_number(100), pick_number(200), pick_zone());
			end else if (pick < 82) begin
				add_cost(pick_zone(), $urandom_range(0, 65535), $urandom_range(0, 65535));
			end else if (pick < 90) begin
				if ($urandom_range(0, 4) == 0)
					add_rate($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 127));
				else
					add_rate($urandom_range(0, 24), $urandom_range(0, 24), $urandom_range(0, 100));
			end else begin
				w = random_word();
				send_word(w);
			end
		end
	endtask

	// fill every table past its depth, then look up across the full exchange table
	task automatic test_table_full();
		gap_max = 14;
		while (exch_fill < EXCH_DEPTH)
			add_exchange($urandom_range(100, 999), $urandom_range(100, 999), pick_zone());
		add_exchange(321, 654, 7);
		add_exchange(999, 999, 0);
		while (cost_fill < COST_DEPTH)
			add_cost(pick_zone(), $urandom_range(0, 65535), $urandom_range(0, 65535));
		add_cost(5, 1, 2);
		while (rate_fill < RATE_DEPTH)
			add_rate($urandom_range(0, 24), $urandom_range(0, 24), $urandom_range(0, 100));
		add_rate(1, 2, 3);
		lookup(int'(exch_tab[EXCH_DEPTH - 1].area), int'(exch_tab[EXCH_DEPTH - 1].exch));
		lookup(int'(exch_tab[0].area), int'(exch_tab[0].exch));
		lookup(101, 102);
		lookup(999, 100);
	endtask

	initial begin
		gap_max = 14;
		exch_fill = 0;
		cost_fill = 0;
		rate_fill = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ADD_EXCH;
		area_num = '0;
		exchange = '0;
		zone = '0;
		first_minute_cost = '0;
		next_minute_cost = '0;
		from_hour = '0;
		to_hour = '0;
		percent_off = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_bad_entries();
		test_lookup_cases();
		test_random_mix(120);
		test_table_full();

		// drop start, wait out every pending word, then watch for strays
		@(negedge clk);
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (errors == 0)
			$display("call_zone_classifier verification clean");
		else
			$display("call_zone_classifier verification failed");
		$finish;
	end

endmodule

FILE: sim.f
design/czc_pkg.sv
design/czc_xcell.sv
design/czc_ccell.sv
design/call_zone_classifier.sv
sim/testbench.sv
